>>> sv/clt_pkg.sv
package clt_pkg;

	// Result kinds as they appear on the kind port.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_TERM = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// Byte codes the parser reacts to.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// One input byte causes at most this many results.
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned RES_W   = $clog2(MAX_RES);
	localparam int unsigned NUM_W   = $clog2(MAX_RES + 1);

	// Depth of the queue between the parser and the output side.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [5:0]  idx;
		logic [6:0]  cnt;
	} result_t;

	// All results caused by one input byte.
	typedef struct packed {
		logic [NUM_W-1:0]          num;
		result_t [MAX_RES-1:0]     res;
	} bundle_t;

	function automatic result_t mk_result(kind_t k, logic [7:0] c, logic [6:0] tf);
		result_t r;
		r.kind = k;
		r.ch   = (k == KIND_BYTE) ? c : 8'h00;
		r.idx  = (k != KIND_END && tf != 7'd0) ? 6'(tf - 7'd1) : 6'd0;
		r.cnt  = tf;
		return r;
	endfunction

endpackage

>>> sv/clt_front.sv
module clt_front #(
	parameter int unsigned TOKEN_LIMIT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  logic [7:0]        char_code,
	input  logic              end_of_input,
	input  logic              q_full,
	output logic              push,
	output clt_pkg::bundle_t  bundle
);

	typedef enum logic [4:0] {
		MODE_BETWEEN = 5'b00001,
		MODE_PLAIN   = 5'b00010,
		MODE_QUOTED  = 5'b00100,
		MODE_SLASH   = 5'b01000,
		MODE_DONE    = 5'b10000
	} mode_t;

	localparam logic [6:0] LIMIT = 7'(TOKEN_LIMIT);

	mode_t       mode_q;
	logic [6:0]  tf_q;
	mode_t       mode_d;
	logic [6:0]  tf_d;
	logic [clt_pkg::NUM_W-1:0] n;
	clt_pkg::result_t [clt_pkg::MAX_RES-1:0] res;
	logic        stop;
	logic        plain;
	logic        accept;

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;
	assign stop       = (char_code == clt_pkg::CH_NUL) || (char_code == clt_pkg::CH_LF) ||
	                    (char_code == clt_pkg::CH_CR);

	// Walks the byte through the parser and collects its results in order.
	always_comb begin
		mode_d = mode_q;
		tf_d   = tf_q;
		n      = '0;
		res    = '0;
		plain  = 1'b0;
		case (mode_q)
			MODE_BETWEEN: begin
				if (tf_d >= LIMIT || stop || char_code == clt_pkg::CH_HASH) begin
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_END, 8'h00, tf_d);
					n      = n + 1'b1;
					mode_d = MODE_DONE;
				end else if (char_code == clt_pkg::CH_SLASH) begin
					mode_d = MODE_SLASH;
				end else if (char_code == clt_pkg::CH_QUOTE) begin
					tf_d   = (tf_d < 7'd127) ? tf_d + 7'd1 : tf_d;
					mode_d = MODE_QUOTED;
				end else if (char_code > clt_pkg::CH_SPACE) begin
					tf_d   = (tf_d < 7'd127) ? tf_d + 7'd1 : tf_d;
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_BYTE, char_code, tf_d);
					n      = n + 1'b1;
					mode_d = MODE_PLAIN;
				end
			end
			MODE_SLASH: begin
				if (char_code == clt_pkg::CH_SLASH) begin
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_END, 8'h00, tf_d);
					n      = n + 1'b1;
					mode_d = MODE_DONE;
				end else begin
					tf_d   = (tf_d < 7'd127) ? tf_d + 7'd1 : tf_d;
					res[n[clt_pkg::RES_W-1:0]] =
						clt_pkg::mk_result(clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH, tf_d);
					n      = n + 1'b1;
					mode_d = MODE_PLAIN;
					plain  = 1'b1;
				end
			end
			MODE_PLAIN: begin
				plain = 1'b1;
			end
			MODE_QUOTED: begin
				if (char_code == clt_pkg::CH_QUOTE) begin
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_TERM, 8'h00, tf_d);
					n = n + 1'b1;
					if (tf_d >= LIMIT) begin
						res[n[clt_pkg::RES_W-1:0]] =
							clt_pkg::mk_result(clt_pkg::KIND_END, 8'h00, tf_d);
						n      = n + 1'b1;
						mode_d = MODE_DONE;
					end else begin
						mode_d = MODE_BETWEEN;
					end
				end else if (char_code == clt_pkg::CH_NUL) begin
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_TERM, 8'h00, tf_d);
					n = n + 1'b1;
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_END, 8'h00, tf_d);
					n      = n + 1'b1;
					mode_d = MODE_DONE;
				end else begin
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_BYTE, char_code, tf_d);
					n = n + 1'b1;
				end
			end
			MODE_DONE: begin
				mode_d = MODE_DONE;
			end
			default: begin
				mode_d = MODE_DONE;
			end
		endcase

		// A byte inside an unquoted token: either more token or its end.
		if (plain) begin
			if (char_code > clt_pkg::CH_SPACE) begin
				res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_BYTE, char_code, tf_d);
				n = n + 1'b1;
			end else begin
				res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_TERM, 8'h00, tf_d);
				n = n + 1'b1;
				if (stop || tf_d >= LIMIT) begin
					res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_END, 8'h00, tf_d);
					n      = n + 1'b1;
					mode_d = MODE_DONE;
				end else begin
					mode_d = MODE_BETWEEN;
				end
			end
		end

		// Close out the line on its last byte.
		if (end_of_input) begin
			if (mode_d == MODE_SLASH) begin
				tf_d   = (tf_d < 7'd127) ? tf_d + 7'd1 : tf_d;
				res[n[clt_pkg::RES_W-1:0]] =
					clt_pkg::mk_result(clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH, tf_d);
				n      = n + 1'b1;
				mode_d = MODE_PLAIN;
			end
			if (mode_d == MODE_PLAIN || mode_d == MODE_QUOTED) begin
				res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_TERM, 8'h00, tf_d);
				n = n + 1'b1;
			end
			if (mode_d != MODE_DONE) begin
				res[n[clt_pkg::RES_W-1:0]] = clt_pkg::mk_result(clt_pkg::KIND_END, 8'h00, tf_d);
				n = n + 1'b1;
			end
			mode_d = MODE_BETWEEN;
			tf_d   = 7'd0;
		end
	end

	assign push       = accept && (n != '0);
	assign bundle.num = n;
	assign bundle.res = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			tf_q   <= 7'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			tf_q   <= tf_d;
		end
	end

endmodule

>>> sv/clt_queue.sv
module clt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  clt_pkg::bundle_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output clt_pkg::bundle_t  head
);

	clt_pkg::bundle_t               entry_q [clt_pkg::QDEPTH];
	logic [clt_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [clt_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [clt_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (count_q == clt_pkg::QCNT_W'(clt_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/clt_back.sv
module clt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  clt_pkg::bundle_t  head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [1:0]        kind,
	output logic [7:0]        out_char,
	output logic [5:0]        token_index,
	output logic [6:0]        token_count,
	output logic              last
);

	logic [clt_pkg::RES_W-1:0] sel_q;
	logic                      valid_q;
	clt_pkg::result_t          res_q;
	logic                      last_q;
	logic                      load;
	logic                      sel_last;

	// The output register takes a new beat when it is empty or being drained.
	assign load     = head_valid && (!valid_q || !result_stall);
	assign sel_last = (clt_pkg::NUM_W'(sel_q) == head.num - 1'b1);
	assign pop      = load && sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= sel_last ? '0 : sel_q + 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.res[sel_q];
			last_q <= sel_last;
		end
	end

	assign result_valid = valid_q;
	assign kind         = res_q.kind;
	assign out_char     = res_q.ch;
	assign token_index  = res_q.idx;
	assign token_count  = res_q.cnt;
	assign last         = last_q;

endmodule

>>> sv/command_line_tokenizer.sv
// Each result beat passes through the queue, then the output register, after its byte is
// accepted. Throughput: one byte per cycle on input unless the queue is full; one result
// beat per cycle on output unless result_stall holds it, so a byte with several results
// (up to four) takes that many beats; the four-entry parser-to-output queue absorbs them.
// Reset: arst_n clears the parser to "between tokens, no tokens found" and empties
// the queue and output register at once; no clearing pass is needed.
module command_line_tokenizer #(
	parameter int unsigned TOKEN_LIMIT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_char,
	output logic [5:0]  token_index,
	output logic [6:0]  token_count,
	output logic        last
);

	// The front end parses each accepted byte combinationally and pushes all of
	// its results as one bundle. Bytes that cause no result (an opening quote, a
	// held slash, blanks between tokens, bytes after the line end) push nothing.
	logic              push;
	clt_pkg::bundle_t  push_data;
	logic              q_full;
	logic              pop;
	logic              head_valid;
	clt_pkg::bundle_t  head;

	clt_front #(
		.TOKEN_LIMIT (TOKEN_LIMIT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.push         (push),
		.bundle       (push_data)
	);

	// The queue decouples the parser from the output: the input stalls only when
	// it is full, which happens when bytes bring results faster than the output drains them.
	clt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The back end steps through the results of the head bundle, one beat per
	// cycle unless result_stall holds it, marking the final beat of each bundle with last.
	clt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.out_char     (out_char),
		.token_index  (token_index),
		.token_count  (token_count),
		.last         (last)
	);

	// A bundle is never split: after a beat without last is taken, the rest of
	// the same bundle is already waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last |=> result_valid)
		else $error("result bundle interrupted before its last beat");

	// Only token bytes carry a character.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != clt_pkg::KIND_BYTE |-> out_char == 8'h00)
		else $error("non-byte result carries a character");

	// The token count never runs past the configured limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> token_count <= 7'(TOKEN_LIMIT))
		else $error("token count above limit");

	// The queue only pushes when it has room, as the input is stalled while full.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !(char_valid && !char_stall))
		else $error("byte accepted while the queue is full");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned LIMIT_TOKENS = 16;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// Parser modes of the predictor. They mirror what the block must track per line.
	typedef enum logic [2:0] {
		M_BETWEEN,
		M_PLAIN,
		M_QUOTED,
		M_SLASH,
		M_DONE
	} tk_mode_t;

	// Ways a generated line is closed: by end_of_input alone or by a byte before it.
	typedef enum int unsigned {
		END_EOI,
		END_LF,
		END_CR,
		END_NUL,
		END_COMMENT
	} line_end_t;

	// One predicted result beat, with every field that the output side carries.
	typedef struct {
		clt_pkg::kind_t kind;
		logic [7:0]     ch;
		logic [5:0]     idx;
		logic [6:0]     cnt;
		logic           last;
	} tok_result_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       char_valid   = 1'b0;
	logic       char_stall;
	logic [7:0] char_code    = 8'h00;
	logic       end_of_input = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_char;
	logic [5:0] token_index;
	logic [6:0] token_count;
	logic       last;

	// Predictor state: parse mode and tokens found on the current line.
	tk_mode_t    tk_mode  = M_BETWEEN;
	logic [6:0]  tk_found = 7'd0;

	// Beats caused by the byte being predicted, and all beats still owed by the block.
	tok_result_t step_results[$];
	tok_result_t expected_results[$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent  = 0;
	int unsigned rx_hold     = 0;

	// When set, neither side inserts idle cycles, so beats go back to back.
	bit quiet = 1'b0;

	command_line_tokenizer #(
		.TOKEN_LIMIT(LIMIT_TOKENS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.end_of_input(end_of_input),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.out_char(out_char),
		.token_index(token_index),
		.token_count(token_count),
		.last(last)
	);

	always #4 clk = ~clk;

	// The run is cut off if the block stops making progress.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Predictor of the token stream.
	// ---------------------------------------------------------------------

	// Queues one result beat for the current byte. The token index is taken from
	// the count of tokens found so far, except on a line end where it is zero.
	task automatic push_result(input clt_pkg::kind_t k, input logic [7:0] c);
		tok_result_t r;
		logic [6:0]  prev;
		prev   = tk_found - 7'd1;
		r.kind = k;
		r.ch   = (k == clt_pkg::KIND_BYTE) ? c : clt_pkg::CH_NUL;
		r.idx  = (k != clt_pkg::KIND_END && tk_found != 7'd0) ? prev[5:0] : 6'd0;
		r.cnt  = tk_found;
		r.last = 1'b0;
		step_results.push_back(r);
	endtask

	task automatic close_line();
		push_result(clt_pkg::KIND_END, clt_pkg::CH_NUL);
		tk_mode = M_DONE;
	endtask

	task automatic open_token();
		if (tk_found < 7'd127)
			tk_found++;
	endtask

	function automatic bit is_line_stop(input logic [7:0] c);
		return c == clt_pkg::CH_NUL || c == clt_pkg::CH_LF || c == clt_pkg::CH_CR;
	endfunction

	// A byte inside a plain token: printable bytes extend it, anything at or
	// below space ends it, and a line-stop byte or the token limit ends the line.
	task automatic plain_byte(input logic [7:0] c);
		if (c > clt_pkg::CH_SPACE) begin
			push_result(clt_pkg::KIND_BYTE, c);
		end else begin
			push_result(clt_pkg::KIND_TERM, clt_pkg::CH_NUL);
			if (is_line_stop(c) || tk_found >= LIMIT_TOKENS)
				close_line();
			else
				tk_mode = M_BETWEEN;
		end
	endtask

	// Works out every beat that one accepted byte causes and appends them, with
	// the last flag on the final one, to the store of beats the block owes.
	task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
		step_results.delete();
		case (tk_mode)
			M_BETWEEN: begin
				if (tk_found >= LIMIT_TOKENS || is_line_stop(c) || c == clt_pkg::CH_HASH) begin
					close_line();
				end else if (c == clt_pkg::CH_SLASH) begin
					tk_mode = M_SLASH;
				end else if (c == clt_pkg::CH_QUOTE) begin
					open_token();
					tk_mode = M_QUOTED;
				end else if (c > clt_pkg::CH_SPACE) begin
					open_token();
					push_result(clt_pkg::KIND_BYTE, c);
					tk_mode = M_PLAIN;
				end
			end
			M_SLASH: begin
				// A second slash is a comment; anything else releases the held slash.
				if (c == clt_pkg::CH_SLASH) begin
					close_line();
				end else begin
					open_token();
					push_result(clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH);
					tk_mode = M_PLAIN;
					plain_byte(c);
				end
			end
			M_PLAIN: begin
				plain_byte(c);
			end
			M_QUOTED: begin
				if (c == clt_pkg::CH_QUOTE) begin
					push_result(clt_pkg::KIND_TERM, clt_pkg::CH_NUL);
					if (tk_found >= LIMIT_TOKENS)
						close_line();
					else
						tk_mode = M_BETWEEN;
				end else if (c == clt_pkg::CH_NUL) begin
					push_result(clt_pkg::KIND_TERM, clt_pkg::CH_NUL);
					close_line();
				end else begin
					push_result(clt_pkg::KIND_BYTE, c);
				end
			end
			default: begin
				tk_mode = M_DONE;
			end
		endcase

		// End of input flushes whatever is still open and rearms for the next line.
		if (eoi) begin
			if (tk_mode == M_SLASH) begin
				open_token();
				push_result(clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH);
				tk_mode = M_PLAIN;
			end
			if (tk_mode == M_PLAIN || tk_mode == M_QUOTED)
				push_result(clt_pkg::KIND_TERM, clt_pkg::CH_NUL);
			if (tk_mode != M_DONE)
				push_result(clt_pkg::KIND_END, clt_pkg::CH_NUL);
			tk_mode  = M_BETWEEN;
			tk_found = 7'd0;
		end

		if (step_results.size() != 0)
			step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endtask

	// ---------------------------------------------------------------------
	// Checking.
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got)
			report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	task automatic check_result();
		tok_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected beat kind %0d char %0d", kind, out_char));
		end else begin
			want = expected_results.pop_front();
			compare_field("kind", 32'(want.kind), 32'(kind));
			compare_field("out_char", 32'(want.ch), 32'(out_char));
			compare_field("token_index", 32'(want.idx), 32'(token_index));
			compare_field("token_count", 32'(want.cnt), 32'(token_count));
			compare_field("last", 32'(want.last), 32'(last));
		end
	endtask

	// Result side. Signals are sampled at the rising edge, before the block's own
	// updates land, so a beat counts exactly when valid was high and stall low.
	// After each accepted beat a fresh number of stall cycles is drawn.
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			check_result();
			rx_hold = quiet ? 0 : $urandom_range(0, 7);
		end else if (rx_hold != 0) begin
			rx_hold--;
		end
		result_stall <= (rx_hold != 0);
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers.
	// ---------------------------------------------------------------------

	// Offers one byte after a random idle gap and returns at the edge where it is
	// taken. Payload stays put while the block stalls. The next call either idles
	// or presents its byte in that same step, so valid is assigned once per step.
	task automatic send_byte(input logic [7:0] c, input logic eoi);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid   <= 1'b1;
		char_code    <= c;
		end_of_input <= eoi;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		tokenize_byte(c, eoi);
		items_sent++;
	endtask

	// Lowers valid and waits until every owed beat has been taken.
	task automatic wait_all_results();
		char_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	function automatic logic [7:0] random_separator();
		logic [7:0] v;
		if ($urandom_range(0, 1) == 0)
			return clt_pkg::CH_SPACE;
		do
			v = 8'($urandom_range(1, 31));
		while (v == clt_pkg::CH_LF || v == clt_pkg::CH_CR);
		return v;
	endfunction

	function automatic logic [7:0] quoted_byte();
		logic [7:0] v;
		do
			v = 8'($urandom_range(1, 255));
		while (v == clt_pkg::CH_QUOTE);
		return v;
	endfunction

	// Builds one well-formed line with random content: plain, quoted and
	// slash-led tokens split by blanks or control bytes, closed by one of the
	// line stops or a comment, maybe with ignored bytes after it. Now and then a
	// line of pure noise with stray end-of-input marks is sent instead.
	task automatic send_random_line(input bit long_line);
		logic [7:0]  line_q[$];
		int unsigned ntok;
		int unsigned len;
		int unsigned style;
		line_end_t   ending;
		bit          quote_left_open;
		if (!long_line && $urandom_range(0, 7) == 0) begin
			len = $urandom_range(1, 10);
			repeat (len)
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			send_byte(8'($urandom_range(0, 255)), 1'b1);
			return;
		end

		ntok = long_line ? $urandom_range(15, 18) : $urandom_range(0, 6);
		quote_left_open = 1'b0;
		if ($urandom_range(0, 3) == 0)
			line_q.push_back(random_separator());
		for (int t = 0; t < ntok; t++) begin
			style = $urandom_range(0, 5);
			len   = long_line ? 1 : $urandom_range(1, 4);
			if (style == 3) begin
				line_q.push_back(clt_pkg::CH_QUOTE);
				repeat ($urandom_range(0, len))
					line_q.push_back(quoted_byte());
				if (t == ntok - 1 && $urandom_range(0, 2) == 0)
					quote_left_open = 1'b1;
				else
					line_q.push_back(clt_pkg::CH_QUOTE);
				// A closing quote already ends the token, so a blank is optional.
				if (!quote_left_open && $urandom_range(0, 1) == 1)
					line_q.push_back(random_separator());
			end else begin
				if (style == 4)
					line_q.push_back(clt_pkg::CH_SLASH);
				repeat (len)
					line_q.push_back(8'($urandom_range(33, 255)));
				line_q.push_back(random_separator());
			end
		end

		ending = line_end_t'($urandom_range(0, 4));
		case (ending)
			END_LF:  line_q.push_back(clt_pkg::CH_LF);
			END_CR:  line_q.push_back(clt_pkg::CH_CR);
			END_NUL: line_q.push_back(clt_pkg::CH_NUL);
			END_COMMENT: begin
				if ($urandom_range(0, 1) == 0) begin
					line_q.push_back(clt_pkg::CH_HASH);
				end else begin
					line_q.push_back(clt_pkg::CH_SLASH);
					line_q.push_back(clt_pkg::CH_SLASH);
				end
			end
			default: ;
		endcase
		if (ending != END_EOI) begin
			repeat ($urandom_range(0, 3))
				line_q.push_back(8'($urandom_range(0, 255)));
		end
		if (line_q.size() == 0)
			line_q.push_back(8'($urandom_range(0, 255)));

		foreach (line_q[i])
			send_byte(line_q[i], i == line_q.size() - 1);
	endtask

	// ---------------------------------------------------------------------
	// Tests.
	// ---------------------------------------------------------------------

	// Hand-picked lines covering the byte extremes and each parser corner.
	task automatic test_directed();
		// Lowest and highest token bytes, a control byte as separator, then a
		// quoted token holding a space that NUL cuts off; the byte after the line
		// end is ignored and its end-of-input gives no second line end.
		send_byte(8'h21, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(clt_pkg::CH_QUOTE, 1'b0);
		send_byte(clt_pkg::CH_SPACE, 1'b0);
		send_byte(clt_pkg::CH_NUL, 1'b0);
		send_byte(8'h41, 1'b1);
		// A slash released by the next byte, then a double-slash comment.
		send_byte(clt_pkg::CH_SLASH, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(clt_pkg::CH_SPACE, 1'b0);
		send_byte(clt_pkg::CH_SLASH, 1'b0);
		send_byte(clt_pkg::CH_SLASH, 1'b0);
		send_byte(8'h71, 1'b1);
		// A slash followed by a separator becomes a token of its own; '#' after
		// blanks is a comment.
		send_byte(clt_pkg::CH_SLASH, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(clt_pkg::CH_HASH, 1'b0);
		send_byte(clt_pkg::CH_LF, 1'b1);
		// A quote right after a closing quote opens a new token, left open at
		// the end of input.
		send_byte(clt_pkg::CH_QUOTE, 1'b0);
		send_byte(8'h71, 1'b0);
		send_byte(clt_pkg::CH_QUOTE, 1'b0);
		send_byte(clt_pkg::CH_QUOTE, 1'b0);
		send_byte(8'h72, 1'b1);
		// A held slash at the end of input, flushed as a token of its own.
		send_byte(clt_pkg::CH_SLASH, 1'b1);
		// Carriage return ending a plain token, and NUL on an empty line.
		send_byte(8'h6B, 1'b0);
		send_byte(clt_pkg::CH_CR, 1'b1);
		send_byte(clt_pkg::CH_NUL, 1'b1);
	endtask

	// The sender holds off until the block has delivered everything it owes.
	task automatic test_drain_pause();
		send_random_line(1'b0);
		wait_all_results();
		send_random_line(1'b0);
	endtask

	// Lines with token counts around the limit, some above it.
	task automatic test_token_limit();
		send_random_line(1'b1);
		send_random_line(1'b1);
	endtask

	task automatic test_random_lines();
		int unsigned start;
		start = items_sent;
		while (items_sent - start < 40) begin
			send_random_line($urandom_range(0, 11) == 0);
		end
	endtask

	// Both sides run without idle cycles, so the output queue fills up.
	task automatic test_back_to_back();
		int unsigned start;
		start = items_sent;
		quiet = 1'b1;
		while (items_sent - start < 30)
			send_random_line(1'b0);
		quiet = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_drain_pause();
		test_token_limit();
		test_random_lines();
		test_back_to_back();

		wait_all_results();
		// Wait on afterwards to catch stray beats.
		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
